>>> rtl/upmc_pkg.sv
// shared types and constants for the udp model id classifier
`timescale 1ns / 1ps

package upmc_pkg;

   // header layout
   localparam int ETH_HDR_LEN     = 14;
   localparam int IP_MIN_LEN      = 20;
   localparam int UDP_HDR_LEN     = 8;
   localparam int CUSTOM_HDR_LEN  = 4;
   localparam int ETHERTYPE_POS   = 12;
   localparam int IP_PROTO_POS    = ETH_HDR_LEN + 9;
   localparam int DPORT_OFS       = 2;
   localparam int MODEL_OFS       = 10;
   localparam int POS_MAX         = 127;

   localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
   localparam logic [7:0]  IP_PROTO_UDP      = 8'd17;
   localparam logic [15:0] LISTEN_PORT_RESET = 16'd9999;

   localparam int TABLE_ENTRIES_DEFAULT = 256;
   localparam int QUEUE_DEPTH           = 2;

   // classified frame, passed from front to back
   typedef struct packed {
      logic        found;
      logic [15:0] model;
   } result_type;

endpackage

>>> rtl/udp_port_model_id_classifier.sv
// top level of the ethernet / ipv4 / udp model id classifier
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  tdata: frame_byte, tlast: end_of_frame
// rsp       out        rsp_tvalid/rsp_tready  tdata: model_number, tuser: verdict
// csr       in         csr_valid/csr_ready    data: listen_port
//
// one frame byte is taken every cycle while the queue has room; a response
// leaves after the last byte through the queue write and then the output register
// synchronous reset clears the byte counter, captured headers, queue and output,
// and loads listen_port with 9999
// a stalled response fills the two-entry queue; req_tready drops only when the
// queue is full, so bytes that end no frame still wait for room
// csr_ready is always high and a write takes effect on the next cycle

module udp_port_model_id_classifier #(
   parameter int TABLE_ENTRIES = upmc_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  logic        req_tlast,   // end_of_frame
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] model_number
   output logic        rsp_tuser,   // [0] verdict
   // listen port register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // [15:0] listen_port
);

   // classified frame out of the front part
   logic                  push_valid;
   upmc_pkg::result_type  push_data;
   logic                  push_ready;

   // head of the queue toward the back part
   logic                  pop_valid;
   upmc_pkg::result_type  pop_data;
   logic                  pop_ready;

   // register writes are always taken
   assign csr_ready  = 1'b1;
   // a request is taken only while the queue can hold a result
   assign req_tready = push_ready;

   // front: counts bytes, captures header fields, decides at the last byte
   upmc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_ready  (push_ready),
      .req_byte   (req_tdata),
      .req_last   (req_tlast),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // decoupling queue between classification and response
   upmc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // back: table range check and response register
   upmc_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> rtl/upmc_front.sv
// front part: byte counter, header capture and frame classification
`timescale 1ns / 1ps

module upmc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_ready,
   input  logic [7:0]            req_byte,
   input  logic                  req_last,
   input  logic                  csr_valid,
   input  logic [15:0]           csr_data,
   output logic                  push_valid,
   output upmc_pkg::result_type  push_data
);

   logic [6:0]  pos_ff, pos_in;
   logic [15:0] etype_ff, etype_in;
   logic [7:0]  proto_ff, proto_in;
   logic [3:0]  hw_ff, hw_in;
   logic [15:0] dport_ff, dport_in;
   logic [15:0] model_ff, model_in;
   logic [15:0] listen_ff, listen_in;

   logic        accept;
   logic [6:0]  udp;
   logic [7:0]  len;
   logic [7:0]  need;
   logic        found;

   assign accept = req_tvalid && req_ready;
   assign udp    = 7'(upmc_pkg::ETH_HDR_LEN) + {1'b0, hw_ff, 2'b00};
   assign len    = {1'b0, pos_ff} + 8'd1;
   assign need   = 8'(upmc_pkg::ETH_HDR_LEN + upmc_pkg::UDP_HDR_LEN
                      + upmc_pkg::CUSTOM_HDR_LEN) + {2'b00, hw_ff, 2'b00};

   // capture of this byte, visible to the verdict on the same byte
   always_comb begin
      etype_in = etype_ff;
      proto_in = proto_ff;
      hw_in    = hw_ff;
      dport_in = dport_ff;
      model_in = model_ff;
      if (pos_ff == 7'(upmc_pkg::ETHERTYPE_POS)) begin
         etype_in[15:8] = req_byte;
      end else if (pos_ff == 7'(upmc_pkg::ETHERTYPE_POS + 1)) begin
         etype_in[7:0] = req_byte;
      end
      if (pos_ff == 7'(upmc_pkg::ETH_HDR_LEN)) begin
         hw_in = req_byte[3:0];
      end
      if (pos_ff == 7'(upmc_pkg::IP_PROTO_POS)) begin
         proto_in = req_byte;
      end
      // udp fields lie past the ihl byte
      if (pos_ff > 7'(upmc_pkg::ETH_HDR_LEN)) begin
         if (pos_ff == udp + 7'(upmc_pkg::DPORT_OFS)) begin
            dport_in[15:8] = req_byte;
         end else if (pos_ff == udp + 7'(upmc_pkg::DPORT_OFS + 1)) begin
            dport_in[7:0] = req_byte;
         end else if (pos_ff == udp + 7'(upmc_pkg::MODEL_OFS)) begin
            model_in[15:8] = req_byte;
         end else if (pos_ff == udp + 7'(upmc_pkg::MODEL_OFS + 1)) begin
            model_in[7:0] = req_byte;
         end
      end
   end

   assign found = (etype_in == upmc_pkg::ETHERTYPE_IPV4)
               && (proto_in == upmc_pkg::IP_PROTO_UDP)
               && (len >= 8'(upmc_pkg::ETH_HDR_LEN + upmc_pkg::IP_MIN_LEN))
               && (len >= need)
               && (dport_in == listen_ff);

   assign push_valid      = accept && req_last;
   assign push_data.found = found;
   assign push_data.model = found ? model_in : 16'd0;

   always_comb begin
      pos_in    = pos_ff;
      listen_in = listen_ff;
      if (csr_valid) begin
         listen_in = csr_data;
      end
      if (accept) begin
         if (req_last) begin
            pos_in = 7'd0;
         end else if (pos_ff < 7'(upmc_pkg::POS_MAX)) begin
            pos_in = pos_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 7'd0;
         etype_ff  <= 16'd0;
         proto_ff  <= 8'd0;
         hw_ff     <= 4'd0;
         dport_ff  <= 16'd0;
         model_ff  <= 16'd0;
         listen_ff <= upmc_pkg::LISTEN_PORT_RESET;
      end else begin
         pos_ff    <= pos_in;
         listen_ff <= listen_in;
         if (accept) begin
            if (req_last) begin
               etype_ff <= 16'd0;
               proto_ff <= 8'd0;
               hw_ff    <= 4'd0;
               dport_ff <= 16'd0;
               model_ff <= 16'd0;
            end else begin
               etype_ff <= etype_in;
               proto_ff <= proto_in;
               hw_ff    <= hw_in;
               dport_ff <= dport_in;
               model_ff <= model_in;
            end
         end
      end
   end

   // frame state is cleared after the last byte
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_last |=> pos_ff == 7'd0 && hw_ff == 4'd0 && model_ff == 16'd0)
      else $error("frame state not cleared after last byte");

   // a model number is only reported for a matching frame
   a_model_needs_found: assert property (@(posedge clock) disable iff (reset)
      push_valid && !push_data.found |-> push_data.model == 16'd0)
      else $error("model number reported for unmatched frame");

endmodule

>>> rtl/upmc_queue.sv
// short queue of classified frames between front and back
`timescale 1ns / 1ps

module upmc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  upmc_pkg::result_type  push_data,
   output logic                  push_ready,
   output logic                  pop_valid,
   output upmc_pkg::result_type  pop_data,
   input  logic                  pop_ready
);

   localparam int DEPTH = upmc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   upmc_pkg::result_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff < CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_no_lost_push: assert property (@(posedge clock) disable iff (reset)
      push_valid && !push_ready |-> count_ff == CNT_W'(DEPTH))
      else $error("push refused while queue has room");

endmodule

>>> rtl/upmc_back.sv
// back part: table range check and registered response
`timescale 1ns / 1ps

module upmc_back #(
   parameter int TABLE_ENTRIES = upmc_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   input  upmc_pkg::result_type  pop_data,
   output logic                  pop_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,
   output logic                  rsp_tuser
);

   logic        valid_ff, valid_in;
   logic        verdict_ff;
   logic [15:0] model_ff;
   logic        in_range;

   assign in_range  = {1'b0, pop_data.model} < 17'(TABLE_ENTRIES);
   assign pop_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (pop_ready) begin
         valid_in = pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         verdict_ff <= pop_data.found && in_range;
         model_ff   <= pop_data.model;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = model_ff;
   assign rsp_tuser  = verdict_ff;

   // dispatch only for ids inside the table
   a_dispatch_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> {1'b0, rsp_tdata} < 17'(TABLE_ENTRIES))
      else $error("dispatch for id outside table");

endmodule
